/* rtl/core/iml_pkg.sv */
// shared types and constants for the ising metropolis lattice block
// no dependencies; imported by iml_ctrl, iml_datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package iml_pkg;

    // default lattice geometry and acceptance compare width
    localparam int IML_SIDE      = 128;
    localparam int IML_PROB_BITS = 32;

    // field widths
    localparam int ROW_W    = 7;
    localparam int COL_W    = 7;
    localparam int RND_W    = 32;
    localparam int THR_W    = 32;
    localparam int ENERGY_W = 18;
    localparam int MAG_W    = 16;
    localparam int DE_W     = 6;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_DE4 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_DE8 = 2'd1;

    localparam logic [THR_W-1:0] THR_DE4_RST = 32'd736900000;
    localparam logic [THR_W-1:0] THR_DE8_RST = 32'd126450000;

    // item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_FLIP = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_MID,
        ST_RD_UP,
        ST_RD_DN,
        ST_EVAL,
        ST_COMMIT
    } iml_state_t;

    typedef enum logic [1:0] {
        SEL_MID,
        SEL_UP,
        SEL_DN
    } iml_rd_sel_t;

    typedef struct packed {
        logic        clear_wr;
        logic        capture;
        iml_rd_sel_t rd_sel;
        logic        cap_mid;
        logic        cap_up;
        logic        eval;
        logic        commit;
    } iml_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } iml_status_t;

endpackage

`default_nettype wire

/* rtl/core/iml_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module iml_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/core/iml_ctrl.sv */
// sequencer for the lattice block: clearing pass, row reads, evaluate, commit
// depends on iml_pkg
`timescale 1ns / 1ps
`default_nettype none

module iml_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire iml_pkg::iml_status_t status,
    output iml_pkg::iml_cmd_t        cmd
);
    import iml_pkg::*;

    iml_state_t state_reg;
    iml_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_RD_MID;
                end
            end
            ST_RD_MID: state_next = ST_RD_UP;
            ST_RD_UP:  state_next = ST_RD_DN;
            ST_RD_DN:  state_next = ST_EVAL;
            ST_EVAL:   state_next = ST_COMMIT;
            ST_COMMIT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.rd_sel   = SEL_MID;
        case (state_reg)
            ST_CLEAR: cmd.clear_wr = 1'b1;
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_RD_MID: cmd.rd_sel = SEL_MID;
            ST_RD_UP: begin
                cmd.rd_sel  = SEL_UP;
                cmd.cap_mid = 1'b1;
            end
            ST_RD_DN: begin
                cmd.rd_sel = SEL_DN;
                cmd.cap_up = 1'b1;
            end
            ST_EVAL:   cmd.eval   = 1'b1;
            ST_COMMIT: cmd.commit = status.out_free;
            default: cmd = '0;
        endcase
    end

    a_accept_starts_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_RD_MID))
        else $error("accepted item did not start the row reads");

    a_commit_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMMIT && !status.out_free) |=> (state_reg == ST_COMMIT))
        else $error("commit left while output register was still full");

    a_clear_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR && !status.clear_last) |=> (state_reg == ST_CLEAR))
        else $error("clearing pass ended early");

endmodule

`default_nettype wire

/* rtl/core/iml_datapath.sv */
// lattice storage, neighbour gather, acceptance decision, energy and
// magnetization accumulators and the result register; depends on iml_pkg, iml_ram
`timescale 1ns / 1ps
`default_nettype none

module iml_datapath #(
    parameter int SIDE      = iml_pkg::IML_SIDE,
    parameter int PROB_BITS = iml_pkg::IML_PROB_BITS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire iml_pkg::iml_cmd_t               cmd,
    output iml_pkg::iml_status_t                 status,
    input  wire logic                            in_kind,
    input  wire logic [iml_pkg::ROW_W-1:0]       in_row,
    input  wire logic [iml_pkg::COL_W-1:0]       in_col,
    input  wire logic                            in_spin_value,
    input  wire logic [iml_pkg::RND_W-1:0]       in_random_fraction,
    input  wire logic                            cfg_we,
    input  wire logic [iml_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [iml_pkg::THR_W-1:0]       cfg_data,
    input  wire logic                            out_ready,
    output logic                                 out_valid,
    output logic                                 out_new_spin,
    output logic                                 out_flipped,
    output logic [iml_pkg::ENERGY_W-1:0]         out_total_energy,
    output logic [iml_pkg::MAG_W-1:0]            out_magnetization
);
    import iml_pkg::*;

    localparam int IDX_W = $clog2(SIDE);
    localparam int LUT_N = 2 ** ROW_W;
    localparam logic [63:0] CELLS = 64'(SIDE) * 64'(SIDE);
    localparam logic [ENERGY_W-1:0] ENERGY_RST = ENERGY_W'(64'd0 - 64'd4 * CELLS);
    localparam logic [MAG_W-1:0]    SUM_RST    = MAG_W'(CELLS);
    localparam logic [MAG_W-1:0]    SUM_UP     = MAG_W'(2);
    localparam logic [MAG_W-1:0]    SUM_DN     = ~MAG_W'(1);
    localparam logic [IDX_W-1:0]    LAST_IDX   = IDX_W'(SIDE - 1);

    // coordinate reduction modulo SIDE, built at elaboration
    logic [IDX_W-1:0] mod_lut [LUT_N];
    for (genvar i = 0; i < LUT_N; i++) begin : g_mod
        localparam int unsigned MODV = i % SIDE;
        assign mod_lut[i] = IDX_W'(MODV);
    end

    // thresholds
    logic [THR_W-1:0] thr_de4_reg;
    logic [THR_W-1:0] thr_de8_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_de4_reg <= THR_DE4_RST;
            thr_de8_reg <= THR_DE8_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_THR_DE4: thr_de4_reg <= cfg_data;
                CFG_THR_DE8: thr_de8_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // item capture
    logic             kind_reg;
    logic [IDX_W-1:0] row_reg;
    logic [IDX_W-1:0] col_reg;
    logic             spin_reg;
    logic [RND_W-1:0] rnd_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg <= in_kind;
            row_reg  <= mod_lut[in_row];
            col_reg  <= mod_lut[in_col];
            spin_reg <= in_spin_value;
            rnd_reg  <= in_random_fraction;
        end
    end

    // torus neighbours
    logic [IDX_W-1:0] row_up;
    logic [IDX_W-1:0] row_dn;
    logic [IDX_W-1:0] col_l;
    logic [IDX_W-1:0] col_r;

    assign row_up = (row_reg == '0) ? LAST_IDX : row_reg - IDX_W'(1);
    assign row_dn = (row_reg == LAST_IDX) ? '0 : row_reg + IDX_W'(1);
    assign col_l  = (col_reg == '0) ? LAST_IDX : col_reg - IDX_W'(1);
    assign col_r  = (col_reg == LAST_IDX) ? '0 : col_reg + IDX_W'(1);

    // lattice memory, one row per word
    logic             clr_cnt_reg;
    logic [IDX_W-1:0] clr_addr_reg;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [SIDE-1:0]  ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [SIDE-1:0]  ram_rdata;
    logic [SIDE-1:0]  mid_row_reg;
    logic             up_bit_reg;
    logic             new_spin_reg;
    logic             flip_reg;
    logic [DE_W-1:0]  de_delta_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            clr_cnt_reg  <= 1'b0;
        end else if (cmd.clear_wr) begin
            clr_addr_reg <= clr_addr_reg + IDX_W'(1);
            clr_cnt_reg  <= (clr_addr_reg == LAST_IDX);
        end
    end

    always_comb begin
        case (cmd.rd_sel)
            SEL_MID: ram_raddr = row_reg;
            SEL_UP:  ram_raddr = row_up;
            SEL_DN:  ram_raddr = row_dn;
            default: ram_raddr = row_reg;
        endcase
    end

    always_comb begin
        ram_wdata = mid_row_reg;
        ram_wdata[col_reg] = new_spin_reg;
        ram_waddr = row_reg;
        ram_we    = cmd.commit;
        if (cmd.clear_wr) begin
            ram_wdata = '1;
            ram_waddr = clr_addr_reg;
            ram_we    = 1'b1;
        end
    end

    iml_ram #(
        .WIDTH (SIDE),
        .DEPTH (SIDE)
    ) u_lattice (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.cap_mid) begin
            mid_row_reg <= ram_rdata;
        end
        if (cmd.cap_up) begin
            up_bit_reg <= ram_rdata[col_reg];
        end
    end

    // decision: count neighbours aligned with the site spin
    logic            s_bit;
    logic [3:0]      match;
    logic [2:0]      aligned;
    logic [PROB_BITS-1:0] rnd_cut;
    logic            flip_eval;
    logic [DE_W-1:0] de_eval;

    assign s_bit   = mid_row_reg[col_reg];
    assign match   = {up_bit_reg ~^ s_bit, ram_rdata[col_reg] ~^ s_bit,
                      mid_row_reg[col_l] ~^ s_bit, mid_row_reg[col_r] ~^ s_bit};
    assign aligned = 3'(match[0]) + 3'(match[1]) + 3'(match[2]) + 3'(match[3]);
    assign rnd_cut = rnd_reg[RND_W-1 -: PROB_BITS];
    // energy change on flip is 4*s*h = 8*aligned - 16
    assign de_eval = DE_W'({aligned, 3'b000}) - DE_W'(16);

    always_comb begin
        if (kind_reg == KIND_LOAD) begin
            flip_eval = (s_bit != spin_reg);
        end else begin
            case (aligned)
                3'd3:    flip_eval = rnd_cut < thr_de4_reg[THR_W-1 -: PROB_BITS];
                3'd4:    flip_eval = rnd_cut < thr_de8_reg[THR_W-1 -: PROB_BITS];
                default: flip_eval = 1'b1;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            flip_reg     <= flip_eval;
            new_spin_reg <= s_bit ^ flip_eval;
            de_delta_reg <= de_eval;
        end
    end

    // accumulators
    logic [ENERGY_W-1:0] energy_reg;
    logic [ENERGY_W-1:0] energy_next;
    logic [MAG_W-1:0]    sum_reg;
    logic [MAG_W-1:0]    sum_next;

    always_comb begin
        energy_next = energy_reg;
        sum_next    = sum_reg;
        if (flip_reg) begin
            energy_next = energy_reg
                        + {{(ENERGY_W-DE_W){de_delta_reg[DE_W-1]}}, de_delta_reg};
            sum_next    = sum_reg + (new_spin_reg ? SUM_UP : SUM_DN);
        end
    end

    logic out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            energy_reg    <= ENERGY_RST;
            sum_reg       <= SUM_RST;
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            energy_reg    <= energy_next;
            sum_reg       <= sum_next;
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_new_spin      <= new_spin_reg;
            out_flipped       <= flip_reg;
            out_total_energy  <= energy_next;
            out_magnetization <= sum_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.clear_last = (clr_addr_reg == LAST_IDX) && !clr_cnt_reg;

    a_commit_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> out_valid_reg)
        else $error("commit did not load the result register");

    a_sum_parity: assert property (@(posedge aclk) disable iff (!aresetn)
        sum_reg[0] == SUM_RST[0])
        else $error("magnetization changed by an odd step");

    a_energy_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        energy_reg[2:0] == ENERGY_RST[2:0])
        else $error("energy changed by a step that is not a multiple of eight");

endmodule

`default_nettype wire

/* rtl/core/ising_metropolis_lattice.sv */
// top level of the 2d ising metropolis lattice block
// depends on iml_pkg, iml_ctrl, iml_datapath (which holds iml_ram)
//
// usage
//   s_ channel carries one item: a load (write one spin) or a flip attempt
//   at a site; m_ channel returns one result per item with the site's new
//   spin, whether it changed, and the running energy and magnetization
//   cfg_ channel writes the two acceptance thresholds (index 0: dE = 4,
//   index 1: dE = 8), unsigned 0.32 fractions; cfg_ready is always high
// item flow
//   a result is loaded into the output register by its item's commit step;
//   the next item is taken only after the three row reads through the single
//   read port of the lattice memory plus the evaluate and commit steps
// reset
//   aresetn is synchronous, active low; afterward a clearing pass writes all
//   spins to +1, one row per cycle over SIDE rows (128 by default), with
//   s_tready low; threshold writes are taken during the pass
// stall
//   the result sits in an output register; the next item is accepted while it
//   waits, and only its commit step waits until m_tready frees the register
`timescale 1ns / 1ps
`default_nettype none

module ising_metropolis_lattice #(
    parameter int SIDE      = iml_pkg::IML_SIDE,
    parameter int PROB_BITS = iml_pkg::IML_PROB_BITS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input items
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // row[6:0], col[13:7], spin_value[14], random_fraction[46:15], zero[47]
    input  wire logic [iml_pkg::S_TDATA_W-1:0]   s_tdata,
    // kind[0]: 0 load, 1 flip attempt
    input  wire logic                            s_tuser,
    // results
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // new_spin[0], flipped[1], total_energy[19:2], magnetization[35:20], zero[39:36]
    output logic [iml_pkg::M_TDATA_W-1:0]        m_tdata,
    // configuration writes
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [iml_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [iml_pkg::THR_W-1:0]       cfg_data
);
    import iml_pkg::*;

    iml_cmd_t    cmd;
    iml_status_t status;

    logic                out_new_spin;
    logic                out_flipped;
    logic [ENERGY_W-1:0] out_total_energy;
    logic [MAG_W-1:0]    out_magnetization;

    // thresholds can be written at any time out of reset
    assign cfg_ready = 1'b1;

    iml_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    iml_datapath #(
        .SIDE      (SIDE),
        .PROB_BITS (PROB_BITS)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .in_kind            (s_tuser),
        .in_row             (s_tdata[6:0]),
        .in_col             (s_tdata[13:7]),
        .in_spin_value      (s_tdata[14]),
        .in_random_fraction (s_tdata[46:15]),
        .cfg_we             (cfg_valid && cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .out_ready          (m_tready),
        .out_valid          (m_tvalid),
        .out_new_spin       (out_new_spin),
        .out_flipped        (out_flipped),
        .out_total_energy   (out_total_energy),
        .out_magnetization  (out_magnetization)
    );

    // pack the result, padded with zeros to whole bytes
    assign m_tdata = {4'b0000, out_magnetization, out_total_energy,
                      out_flipped, out_new_spin};

endmodule

`default_nettype wire
